// ----- rtl/pixel_temporal_kalman_filter_macros.svh -----
// Assertion macros shared by the pixel temporal Kalman filter RTL.
`ifndef PIXEL_TEMPORAL_KALMAN_FILTER_MACROS_SVH
`define PIXEL_TEMPORAL_KALMAN_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define PTKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptkf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptkf assertion failed");

`else

`define PTKF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTKF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/ptkf_pkg.sv -----
// Types and constants shared by the pixel temporal Kalman filter modules.
`default_nettype none

package ptkf_pkg;

    // Field and register widths
    localparam int IDX_W      = 14;
    localparam int VAL_W      = 8;
    localparam int DEPTH_W    = 16;
    localparam int IN_DATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int MIX_W      = 9;
    localparam int NF_W       = 20;
    localparam int UNIT_W     = 4;
    localparam int DSQ_W      = 16;
    localparam int VM_W       = 24;
    localparam int DEN_W      = 25;
    localparam int K_W        = 8;
    localparam int STATE_W    = 2 * VAL_W;

    // Pipeline layout: stage 4 forms the divisor, stages 5 to 12 each
    // retire one quotient bit, stage 12 holds the finished gain.
    localparam int LAST_STAGE = 13;
    localparam int DIV_FIRST  = 4;
    localparam int DIV_LAST   = 12;

    // Register reset values
    localparam logic [MIX_W-1:0]  MIX_GAIN_RST    = 9'd26;
    localparam logic [NF_W-1:0]   NOISE_FLOOR_RST = 20'd16384;
    localparam logic [VAL_W-1:0]  VAR_LIMIT_RST   = 8'd32;
    localparam logic [UNIT_W-1:0] DEPTH_UNIT_RST  = 4'd2;

    // Arithmetic constants
    localparam logic [MIX_W-1:0]   FULL_GAIN  = 9'd256;
    localparam logic [UNIT_W-1:0]  UNIT_MIN   = 4'd1;
    localparam logic [UNIT_W-1:0]  UNIT_MAX   = 4'd9;
    localparam logic [VAL_W-1:0]  VAL_MAX     = 8'd255;
    localparam logic [DEPTH_W-1:0] MASK_DEPTH = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIX_GAIN    = 2'd0,
        REG_NOISE_FLOOR = 2'd1,
        REG_VAR_LIMIT   = 2'd2,
        REG_DEPTH_UNIT  = 2'd3
    } cfg_reg_t;

    // Per-pixel fields that travel the whole pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             in_range;
        logic [VAL_W-1:0] median;
        logic [VAL_W-1:0] raw;
        logic             first;
        logic [VAL_W-1:0] average;
        logic [VAL_W-1:0] variance;
    } item_t;

endpackage

`default_nettype wire

// ----- rtl/ptkf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ptkf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/pixel_temporal_kalman_filter.sv -----
// Pixel temporal Kalman filter: per-pixel smoothing pipeline with depth masking.
//
// Usage notes.
// Pixels arrive on the s_axis stream and one result per pixel leaves on the
// m_axis stream, in arrival order. A transaction takes place when tvalid and
// tready are both high at a rising clock edge.
// The result of a pixel is registered on m_axis as it leaves the last stage.
// The pipeline takes one pixel per cycle unless a hazard or a receiver stall
// holds it off; an eight-stage restoring divider forms the blend gain.
// The per-pixel average and variance sit in one RAM that is read when a pixel
// enters and written as it leaves stage 13. A pixel whose index matches one
// still in flight is held off (s_axis_tready low) until that one has been
// written back; distinct pixels run at full rate while the receiver keeps up.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while the pipeline is empty; the block does not
// enforce it. Reset restores the register defaults and empties the pipeline;
// the pixel store is not cleared, and an entry holds until a pixel writes it.
// When the receiver stalls, each stage keeps its item and empty stages still
// fill, so input keeps flowing until the pipeline is full.
`default_nettype none
`include "pixel_temporal_kalman_filter_macros.svh"

module pixel_temporal_kalman_filter #(
    parameter int NUM_PIXELS = 10000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_write,
    input  logic [ptkf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptkf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pixel_index [13:0], median_value [21:14], raw_value [29:22], zero [31:30]
    input  logic [ptkf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: first_frame
    input  logic                                s_axis_tuser,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: depth_out [15:0]
    output logic [ptkf_pkg::DEPTH_W-1:0]        m_axis_tdata,
    // tuser: masked
    output logic                                m_axis_tuser
);

    import ptkf_pkg::*;

    localparam int ADDR_W  = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int IDXX_W  = 17;
    localparam logic [IDXX_W-1:0] PIXEL_COUNT = IDXX_W'(NUM_PIXELS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MIX_W-1:0]  mix_gain_reg;
    logic [NF_W-1:0]   noise_floor_reg;
    logic [VAL_W-1:0]  var_limit_reg;
    logic [UNIT_W-1:0] depth_unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_gain_reg    <= MIX_GAIN_RST;
            noise_floor_reg <= NOISE_FLOOR_RST;
            var_limit_reg   <= VAR_LIMIT_RST;
            depth_unit_reg  <= DEPTH_UNIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIX_GAIN:    mix_gain_reg    <= cfg_data[MIX_W-1:0];
                REG_NOISE_FLOOR: noise_floor_reg <= cfg_data[NF_W-1:0];
                REG_VAR_LIMIT:   var_limit_reg   <= cfg_data[VAL_W-1:0];
                REG_DEPTH_UNIT:  depth_unit_reg  <= cfg_data[UNIT_W-1:0];
                default:         mix_gain_reg    <= mix_gain_reg;
            endcase
        end
    end

    // Saturated forms of the registers
    logic [MIX_W-1:0]  gain_fi;
    logic [MIX_W-1:0]  gain_cfi;
    logic [NF_W-1:0]   noise_mn;
    logic [UNIT_W-1:0] unit_sat;

    always_comb
    begin
        gain_fi  = (mix_gain_reg > FULL_GAIN) ? FULL_GAIN : mix_gain_reg;
        gain_cfi = FULL_GAIN - gain_fi;
        noise_mn = (noise_floor_reg == '0) ? NF_W'(1) : noise_floor_reg;
        if (depth_unit_reg < UNIT_MIN)
        begin
            unit_sat = UNIT_MIN;
        end
        else if (depth_unit_reg > UNIT_MAX)
        begin
            unit_sat = UNIT_MAX;
        end
        else
        begin
            unit_sat = depth_unit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                        valid_reg [1:LAST_STAGE];
    item_t                       item_reg  [1:LAST_STAGE];
    item_t                       item_next [1:LAST_STAGE];
    logic signed [VAL_W:0]       diff_reg  [2:DIV_LAST];
    logic signed [VAL_W:0]       diff_next [2:DIV_LAST];
    logic [VM_W-1:0]             vm_reg    [3:DIV_LAST];
    logic [VM_W-1:0]             vm_next   [3:DIV_LAST];
    logic [DEN_W-1:0]            den_reg   [DIV_FIRST:DIV_LAST];
    logic [DEN_W-1:0]            den_next  [DIV_FIRST:DIV_LAST];
    logic [DEN_W-1:0]            rem_reg   [DIV_FIRST:DIV_LAST];
    logic [DEN_W-1:0]            rem_next  [DIV_FIRST:DIV_LAST];
    logic [K_W-1:0]              quo_reg   [DIV_FIRST:DIV_LAST];
    logic [K_W-1:0]              quo_next  [DIV_FIRST:DIV_LAST];
    logic [DSQ_W-1:0]            dsq_reg;
    logic [DSQ_W-1:0]            dsq_next;
    logic [DSQ_W-1:0]            cv_reg;
    logic [DSQ_W-1:0]            cv_next;
    logic signed [18:0]          anum_reg;
    logic signed [18:0]          anum_next;
    logic [31:0]                 vprod_reg;
    logic [31:0]                 vprod_next;

    logic                        out_valid_reg;
    logic [DEPTH_W-1:0]          out_depth_reg;
    logic [DEPTH_W-1:0]          out_depth_next;
    logic                        out_masked_reg;
    logic                        out_masked_next;

    // Stage i loads when it is empty or its item moves on
    logic                        adv [1:LAST_STAGE+1];

    always_comb
    begin
        adv[LAST_STAGE+1] = !out_valid_reg || m_axis_tready;
        for (int i = LAST_STAGE; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking and same-pixel hazard check
    // ------------------------------------------------------------------
    item_t             in_item;
    logic [IDXX_W-1:0] in_idx_wide;
    logic              hazard;
    logic              in_accept;

    always_comb
    begin
        in_item          = '0;
        in_item.idx      = s_axis_tdata[IDX_W-1:0];
        in_item.median   = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
        in_item.raw      = s_axis_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
        in_item.first    = s_axis_tuser;
        in_idx_wide      = {{(IDXX_W-IDX_W){1'b0}}, in_item.idx};
        in_item.in_range = (in_idx_wide < PIXEL_COUNT);
    end

    always_comb
    begin
        hazard = 1'b0;
        for (int i = 1; i <= LAST_STAGE; i++)
        begin
            if (valid_reg[i] && (item_reg[i].idx == in_item.idx))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign s_axis_tready = adv[1] && !hazard;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Pixel state store: {average, variance}
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [IDXX_W-1:0]  wb_idx_wide;
    logic               ram_we;
    logic [STATE_W-1:0] ram_wdata;
    logic [STATE_W-1:0] ram_rdata;
    logic [VAL_W-1:0]   wb_average;
    logic [VAL_W-1:0]   wb_variance;

    assign ram_raddr   = in_idx_wide[ADDR_W-1:0];
    assign wb_idx_wide = {{(IDXX_W-IDX_W){1'b0}}, item_reg[LAST_STAGE].idx};
    assign ram_waddr   = wb_idx_wide[ADDR_W-1:0];
    assign ram_wdata   = {wb_average, wb_variance};
    assign ram_we      = valid_reg[LAST_STAGE] && adv[LAST_STAGE+1]
                         && item_reg[LAST_STAGE].in_range;

    ptkf_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_PIXELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv[1]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stages 1 to 13: next values of every payload stage
    // ------------------------------------------------------------------
    logic signed [2*VAL_W+1:0]   sq_full;
    logic [DSQ_W:0]              cv_full;
    logic [DEN_W-1:0]            fdsq_full;
    logic [DEN_W-1:0]            vm_full;
    logic [DEN_W:0]              rem_shift [DIV_FIRST+1:DIV_LAST];
    logic signed [K_W+VAL_W+1:0] kd_prod;
    logic [MIX_W-1:0]            k_comp;
    logic [VM_W-2:0]             vm_half;

    always_comb
    begin
        // Stage 1 to 2: the RAM data arrives with stage 1
        item_next[1]          = in_item;
        item_next[2]          = item_reg[1];
        item_next[2].average  = ram_rdata[STATE_W-1:VAL_W];
        item_next[2].variance = ram_rdata[VAL_W-1:0];
        diff_next[2] = $signed({1'b0, item_next[2].median})
                     - $signed({1'b0, item_next[2].average});
        sq_full  = diff_next[2] * diff_next[2];
        dsq_next = sq_full[DSQ_W-1:0];
        cv_full  = {8'b0, gain_cfi} * {9'b0, item_next[2].variance};
        cv_next  = cv_full[DSQ_W-1:0];

        // Stage 2 to 3: vm = cfi*var + fi*diff*diff
        item_next[3] = item_reg[2];
        diff_next[3] = diff_reg[2];
        fdsq_full    = {{(DEN_W-MIX_W){1'b0}}, gain_fi} * {{(DEN_W-DSQ_W){1'b0}}, dsq_reg};
        vm_full      = {{(DEN_W-DSQ_W){1'b0}}, cv_reg} + fdsq_full;
        vm_next[3]   = vm_full[VM_W-1:0];

        // Stages 3 to 12: k = floor(vm*256 / (vm + mn)), one bit a stage.
        // Divisor and the first partial remainder; vm is always below it.
        item_next[DIV_FIRST] = item_reg[DIV_FIRST-1];
        diff_next[DIV_FIRST] = diff_reg[DIV_FIRST-1];
        vm_next[DIV_FIRST]   = vm_reg[DIV_FIRST-1];
        den_next[DIV_FIRST]  = {1'b0, vm_reg[DIV_FIRST-1]}
                             + {{(DEN_W-NF_W){1'b0}}, noise_mn};
        rem_next[DIV_FIRST]  = {1'b0, vm_reg[DIV_FIRST-1]};
        quo_next[DIV_FIRST]  = '0;

        // Restoring steps: the dividend's low bits are all zero
        for (int i = DIV_FIRST + 1; i <= DIV_LAST; i++)
        begin
            item_next[i] = item_reg[i-1];
            diff_next[i] = diff_reg[i-1];
            vm_next[i]   = vm_reg[i-1];
            den_next[i]  = den_reg[i-1];
            rem_shift[i] = {rem_reg[i-1], 1'b0};
            if (rem_shift[i] >= {1'b0, den_reg[i-1]})
            begin
                rem_next[i] = DEN_W'(rem_shift[i] - {1'b0, den_reg[i-1]});
                quo_next[i] = {quo_reg[i-1][K_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem_shift[i][DEN_W-1:0];
                quo_next[i] = {quo_reg[i-1][K_W-2:0], 1'b0};
            end
        end

        // Stage 12 to 13: average numerator and variance product
        item_next[LAST_STAGE] = item_reg[DIV_LAST];
        kd_prod   = $signed({1'b0, quo_reg[DIV_LAST]}) * diff_reg[DIV_LAST];
        anum_next = $signed({3'b000, item_reg[DIV_LAST].average, 8'h00})
                  + $signed({kd_prod[K_W+VAL_W+1], kd_prod})
                  + 19'sd128;
        k_comp     = FULL_GAIN - {1'b0, quo_reg[DIV_LAST]};
        vm_half    = vm_reg[DIV_LAST][VM_W-1:1];
        vprod_next = {{(32-MIX_W){1'b0}}, k_comp} * {{(32-VM_W+1){1'b0}}, vm_half};
    end

    // ------------------------------------------------------------------
    // Stage 13: clamp, first-frame override, masking and depth
    // ------------------------------------------------------------------
    logic signed [10:0] avg_shift;
    logic [32:0]        var_sum;
    logic [17:0]        var_shift;
    logic [11:0]        unit_avg;

    always_comb
    begin
        // Arithmetic shift of the numerator floors negative values
        avg_shift = anum_reg[18:8];
        var_sum   = {1'b0, vprod_reg} + 33'd16384;
        var_shift = var_sum[32:15];

        if (avg_shift <= 11'sd0)
        begin
            wb_average = '0;
        end
        else if (avg_shift >= 11'sd255)
        begin
            wb_average = VAL_MAX;
        end
        else
        begin
            wb_average = avg_shift[VAL_W-1:0];
        end

        if (var_shift > 18'd255)
        begin
            wb_variance = VAL_MAX;
        end
        else
        begin
            wb_variance = var_shift[VAL_W-1:0];
        end

        // A first frame takes the measurement and zero variance
        if (item_reg[LAST_STAGE].first)
        begin
            wb_average  = item_reg[LAST_STAGE].median;
            wb_variance = '0;
        end

        unit_avg = {8'b0, unit_sat} * {4'b0, wb_average};

        out_masked_next = !item_reg[LAST_STAGE].in_range
                          || (item_reg[LAST_STAGE].raw == VAL_MAX)
                          || (wb_average == VAL_MAX)
                          || (wb_variance > var_limit_reg);
        out_depth_next  = out_masked_next ? MASK_DEPTH : {2'b00, unit_avg, 2'b00};
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAST_STAGE; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= s_axis_tvalid && !hazard;
            end
            for (int i = 2; i <= LAST_STAGE; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
            if (adv[LAST_STAGE+1])
            begin
                out_valid_reg <= valid_reg[LAST_STAGE];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= LAST_STAGE; i++)
        begin
            if (adv[i])
            begin
                item_reg[i] <= item_next[i];
            end
        end
        for (int i = 2; i <= DIV_LAST; i++)
        begin
            if (adv[i])
            begin
                diff_reg[i] <= diff_next[i];
            end
        end
        for (int i = 3; i <= DIV_LAST; i++)
        begin
            if (adv[i])
            begin
                vm_reg[i] <= vm_next[i];
            end
        end
        for (int i = DIV_FIRST; i <= DIV_LAST; i++)
        begin
            if (adv[i])
            begin
                den_reg[i] <= den_next[i];
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
        if (adv[2])
        begin
            dsq_reg <= dsq_next;
            cv_reg  <= cv_next;
        end
        if (adv[LAST_STAGE])
        begin
            anum_reg  <= anum_next;
            vprod_reg <= vprod_next;
        end
        if (adv[LAST_STAGE+1])
        begin
            out_depth_reg  <= out_depth_next;
            out_masked_reg <= out_masked_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_depth_reg;
    assign m_axis_tuser  = out_masked_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted transaction always lands in the first stage.
    `PTKF_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_accept, valid_reg[1])
    // Pixels outside the frame never touch the store.
    `PTKF_ASSERT_IMP(a_no_stray_write, clk, rst_n, ram_we, item_reg[LAST_STAGE].in_range)
    // The finished partial remainder of a stored pixel stays below the divisor.
    `PTKF_ASSERT_IMP(a_div_rem_bound, clk, rst_n,
        valid_reg[DIV_LAST] && item_reg[DIV_LAST].in_range && !item_reg[DIV_LAST].first,
        rem_reg[DIV_LAST] < den_reg[DIV_LAST])
    // A masked result always carries the saturated depth code.
    `PTKF_ASSERT_IMP(a_mask_depth, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == MASK_DEPTH)

endmodule

`default_nettype wire
